[sv/lms_adaptive_noise_canceller_defines.svh]
`ifndef LMS_ADAPTIVE_NOISE_CANCELLER_DEFINES_SVH
`define LMS_ADAPTIVE_NOISE_CANCELLER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LMS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lms_pkg.sv]
`timescale 1ns / 1ps

package lms_pkg;

  localparam int TapsDefault = 30;
  localparam int SampleW     = 16;
  localparam int WeightW     = 32;
  localparam int StepW       = 16;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;

  localparam logic [StepW-1:0] StepReset = 16'd1100;
  localparam logic             SelReset  = 1'b0;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegStepSize     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOutputSelect = 2'd1;

  typedef struct packed {
    logic [StepW-1:0] step_size;
    logic             output_select;
  } lms_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_EST,
    ST_OUT,
    ST_UPD
  } lms_state_e;

endpackage

[sv/lms_in_if.sv]
`timescale 1ns / 1ps

interface lms_in_if import lms_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] reference_sample;
  logic signed [SampleW-1:0] desired_sample;

  modport source (output valid, output reference_sample, output desired_sample,
                  input ready);
  modport sink (input valid, input reference_sample, input desired_sample,
                output ready);
endinterface

[sv/lms_out_if.sv]
`timescale 1ns / 1ps

interface lms_out_if import lms_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

[sv/lms_ram.sv]
`timescale 1ns / 1ps

module lms_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/lms_engine.sv]
`timescale 1ns / 1ps
`include "lms_adaptive_noise_canceller_defines.svh"

module lms_engine import lms_pkg::*; #(
  parameter int TAPS = TapsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lms_cfg_t                  cfg_i,
  lms_in_if.sink                    in_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic signed [SampleW-1:0] res_sample_o
);

  localparam int IW    = $clog2(TAPS);
  localparam int AccW  = 2 * SampleW + SampleW + IW;
  localparam int EstW  = AccW - 30;
  localparam int ErrW  = SampleW + 1;
  localparam int SeW   = ErrW + StepW + 1;
  localparam int ProdW = SeW + SampleW;
  localparam int NwW   = ProdW - 10 + 1;
  localparam int X10W  = ErrW + 4;
  localparam logic [IW-1:0] LastIdx = IW'(TAPS - 1);

  localparam logic signed [EstW-1:0]    EstMax = EstW'(32767);
  localparam logic signed [EstW-1:0]    EstMin = -EstW'(32768);
  localparam logic signed [NwW-1:0]     WMax   = NwW'(64'sd2147483647);
  localparam logic signed [NwW-1:0]     WMin   = -NwW'(64'sd2147483648);
  localparam logic signed [X10W-1:0]    OMax   = X10W'(32767);
  localparam logic signed [X10W-1:0]    OMin   = -X10W'(32768);

  lms_state_e state_q, state_d;

  logic [IW-1:0] idx_q, idx_d, daddr_q, daddr_d, base_q, base_d;
  logic          issue_q, issue_d, s1_q, s2_q, last1_q, last2_q;
  logic [TAPS-1:0] wvalid_q, dvalid_q;

  logic signed [SampleW-1:0] desired_q;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [ErrW-1:0]    err_q, err_d;
  logic signed [SeW-1:0]     step_err_q, step_err_d;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic signed [WeightW-1:0] wq_q;
  logic [IW-1:0]             idx1_q, idx2_q;
  logic                      wv1_q, dv1_q;

  logic                      d_we, rd_en, w_we;
  logic [SampleW-1:0]        d_rdata;
  logic [WeightW-1:0]        w_rdata;
  logic signed [WeightW-1:0] w_op, w_new;
  logic signed [SampleW-1:0] d_op;
  logic signed [SeW-1:0]     mul_a;
  logic signed [EstW-1:0]    est_full;
  logic signed [SampleW-1:0] est;
  logic signed [NwW-1:0]     nw;
  logic signed [ErrW-1:0]    sel;
  logic signed [X10W-1:0]    x10;
  logic                      in_beat;

  // delay line as a ring: tap i sits at base + i
  lms_ram #(.Width(SampleW), .Depth(TAPS)) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (base_d),
    .wdata_i (in_i.reference_sample),
    .re_i    (rd_en),
    .raddr_i (daddr_q),
    .rdata_o (d_rdata)
  );

  lms_ram #(.Width(WeightW), .Depth(TAPS)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (idx2_q),
    .wdata_i (w_new),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (w_rdata)
  );

  assign in_beat  = in_i.valid && in_i.ready;
  assign d_we     = in_beat;
  assign rd_en    = issue_q;
  assign w_we     = (state_q == ST_UPD) && s2_q;

  // entries never written read as zero
  assign w_op  = wv1_q ? $signed(w_rdata) : '0;
  assign d_op  = dv1_q ? $signed(d_rdata) : '0;
  assign mul_a = (state_q == ST_UPD) ? step_err_q : SeW'(w_op);
  assign prod_d = ProdW'(mul_a) * ProdW'(d_op);

  assign est_full = acc_q[AccW-1:30];
  assign est = (est_full > EstMax) ? SampleW'(EstMax) :
               (est_full < EstMin) ? SampleW'(EstMin) : SampleW'(est_full);
  assign err_d = ErrW'(desired_q) - ErrW'(est);
  assign step_err_d = SeW'($signed({1'b0, cfg_i.step_size})) * SeW'(err_q);

  // weight update: floor(prod / 2^10) then saturate to 32 bits
  assign nw = NwW'(wq_q) + NwW'(prod_q >>> 10);
  assign w_new = (nw > WMax) ? WeightW'(WMax) :
                 (nw < WMin) ? WeightW'(WMin) : WeightW'(nw);

  assign sel = cfg_i.output_select ? ErrW'(desired_q) : err_q;
  assign x10 = (X10W'(sel) <<< 3) + (X10W'(sel) <<< 1);
  assign res_sample_o = (x10 > OMax) ? SampleW'(OMax) :
                        (x10 < OMin) ? SampleW'(OMin) : SampleW'(x10);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    daddr_d     = daddr_q;
    base_d      = base_q;
    issue_d     = issue_q;
    acc_d       = acc_q;
    in_i.ready  = 1'b0;
    res_valid_o = 1'b0;
    if (issue_q) begin
      idx_d   = idx_q + 1'b1;
      daddr_d = (daddr_q == LastIdx) ? '0 : daddr_q + 1'b1;
      if (idx_q == LastIdx) begin
        issue_d = 1'b0;
      end
    end
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          base_d  = (base_q == '0) ? LastIdx : base_q - 1'b1;
          idx_d   = '0;
          daddr_d = base_d;
          issue_d = 1'b1;
          acc_d   = '0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (s2_q) begin
          acc_d = acc_q + AccW'(prod_q);
          if (last2_q) begin
            state_d = ST_EST;
          end
        end
      end
      ST_EST: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          idx_d   = '0;
          daddr_d = base_q;
          issue_d = 1'b1;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (s2_q && last2_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      daddr_q  <= '0;
      base_q   <= '0;
      issue_q  <= 1'b0;
      s1_q     <= 1'b0;
      s2_q     <= 1'b0;
      last1_q  <= 1'b0;
      last2_q  <= 1'b0;
      wvalid_q <= '0;
      dvalid_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      daddr_q <= daddr_d;
      base_q  <= base_d;
      issue_q <= issue_d;
      s1_q    <= issue_q;
      s2_q    <= s1_q;
      last1_q <= issue_q && (idx_q == LastIdx);
      last2_q <= last1_q;
      if (d_we) begin
        dvalid_q[base_d] <= 1'b1;
      end
      if (w_we) begin
        wvalid_q[idx2_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      desired_q <= in_i.desired_sample;
    end
    acc_q  <= acc_d;
    prod_q <= prod_d;
    wq_q   <= w_op;
    wv1_q  <= wvalid_q[idx_q];
    dv1_q  <= dvalid_q[daddr_q];
    idx1_q <= idx_q;
    idx2_q <= idx1_q;
    if (state_q == ST_EST) begin
      err_q <= err_d;
    end
    if (state_q == ST_OUT) begin
      step_err_q <= step_err_d;
    end
  end

  `LMS_ASSERT_NEXT(a_new_tap_valid, in_i.valid && in_i.ready, dvalid_q[base_q], "new reference sample not marked valid")
  `LMS_ASSERT_NEXT(a_beat_starts_update, res_valid_o && res_ready_i, state_q == ST_UPD, "result beat did not start the weight update")
  `LMS_ASSERT_SAME(a_wb_addr_trails, w_we, idx2_q == $past(idx_q, 2), "weight write-back address does not trail its read")
  `LMS_ASSERT_SAME(a_acc_from_pipe, (state_q == ST_MAC) && s2_q, $past(s1_q), "mac product without a read behind it")

endmodule

[sv/lms_adaptive_noise_canceller.sv]
`timescale 1ns / 1ps
// channel   dir  beat payload
// cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i (step_size, output_select)
// in_i      in   reference_sample, desired_sample
// out_o     out  out_sample
//
// one item at a time: the next input beat is taken only once the weight update of the
// last one is done; the loop is one tap a cycle through a single multiplier fed by
// the weight and delay memories, once for the estimate and once for the weight update
// the result leaves through an output register; the update starts once it is taken
// a full output register holds the engine at its result and input waits
// reset clears weights and delay line at once through per-entry valid bits

module lms_adaptive_noise_canceller import lms_pkg::*; #(
  parameter int TAPS = TapsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  lms_in_if.sink              in_i,
  lms_out_if.source           out_o
);

  lms_cfg_t cfg_q, cfg_d;

  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_sample_q;
  logic                      res_valid, res_ready;
  logic signed [SampleW-1:0] res_sample;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStepSize:     cfg_d.step_size     = cfg_wdata_i[StepW-1:0];
        RegOutputSelect: cfg_d.output_select = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size     <= StepReset;
      cfg_q.output_select <= SelReset;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_sample_q <= res_sample;
    end
  end

  assign res_ready        = !out_valid_q || out_o.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.out_sample = out_sample_q;

  lms_engine #(.TAPS(TAPS)) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_sample_o (res_sample)
  );

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import lms_pkg::*;

  localparam int TAPS          = TapsDefault;
  localparam int SETTLE_CYCLES = 2 * TAPS + 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 160;

  // indexes past the last register, ignored by the block
  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

  class canceller_scoreboard;
    logic signed [WeightW-1:0] weight [TAPS];
    logic signed [SampleW-1:0] tap_hist [TAPS];
    logic [StepW-1:0]          step_size;
    logic                      output_select;
    logic signed [SampleW-1:0] pending_out [$];
    int                        mismatch_count;

    function new();
      int i;
      for (i = 0; i < TAPS; i++) begin
        weight[i]   = '0;
        tap_hist[i] = '0;
      end
      step_size      = StepReset;
      output_select  = SelReset;
      mismatch_count = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == RegStepSize) begin
        step_size = val[StepW-1:0];
      end else if (idx == RegOutputSelect) begin
        output_select = val[0];
      end
    endfunction

    // one accepted beat: shift, estimate, error, adapt, queue the output
    function void take_sample(logic signed [SampleW-1:0] noise_s,
                              logic signed [SampleW-1:0] primary_s);
      int     i;
      longint acc, est, err, prod, nw, sel;
      for (i = TAPS - 1; i > 0; i--) tap_hist[i] = tap_hist[i-1];
      tap_hist[0] = noise_s;
      acc = 0;
      for (i = 0; i < TAPS; i++) acc += longint'(weight[i]) * longint'(tap_hist[i]);
      est = clip(acc >>> 30, -32768, 32767);
      err = longint'(primary_s) - est;
      for (i = 0; i < TAPS; i++) begin
        prod = longint'(step_size) * err * longint'(tap_hist[i]);
        nw = longint'(weight[i]) + (prod >>> 10);
        weight[i] = WeightW'(clip(nw, -64'sd2147483648, 64'sd2147483647));
      end
      sel = output_select ? longint'(primary_s) : err;
      sel = clip(sel * 10, -32768, 32767);
      pending_out.push_back(sel[SampleW-1:0]);
    endfunction

    function void check_out(logic signed [SampleW-1:0] actual);
      logic signed [SampleW-1:0] want;
      if (pending_out.size() == 0) begin
        $error("out_sample: nothing expected, actual %0d", actual);
        mismatch_count++;
      end else begin
        want = pending_out.pop_front();
        if (actual !== want) begin
          $error("out_sample: expected %0d, actual %0d", want, actual);
          mismatch_count++;
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  lms_in_if  in_if ();
  lms_out_if out_if ();

  canceller_scoreboard sb;
  bit  calm;
  bit  hold_req;
  int  cycle_count;

  lms_adaptive_noise_canceller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[lms_adaptive_noise_canceller] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.take_sample(in_if.reference_sample, in_if.desired_sample);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_out(out_if.out_sample);
      end
    end
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_sample(logic signed [SampleW-1:0] noise_s,
                             logic signed [SampleW-1:0] primary_s);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.reference_sample <= noise_s;
    in_if.desired_sample   <= primary_s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // the weight update runs on after the output beat, so wait it out too
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [StepW-1:0] step_v, logic sel_v);
    logic [CfgDataW-1:0] sel_word, junk;
    logic [CfgIdxW-1:0]  spare_idx;
    sel_word    = CfgDataW'($urandom);
    sel_word[0] = sel_v;
    junk        = CfgDataW'($urandom);
    spare_idx   = $urandom_range(0, 1) ? RegSpareHi : RegSpareLo;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegStepSize;
    cfg_wdata_i <= step_v;
    @(posedge clk_i);
    sb.set_reg(RegStepSize, step_v);
    cfg_idx_i   <= RegOutputSelect;
    cfg_wdata_i <= sel_word;
    @(posedge clk_i);
    sb.set_reg(RegOutputSelect, sel_word);
    cfg_idx_i   <= spare_idx;
    cfg_wdata_i <= junk;
    @(posedge clk_i);
    sb.set_reg(spare_idx, junk);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly a noise source leaking into the primary channel through a short
  // path, plus a small signal; the rest is unrelated full-range beats
  task automatic run_phase(int n_items);
    int                        k, amp_shift, d;
    logic [SampleW-1:0]        raw_a, raw_b;
    logic signed [SampleW-1:0] n_now, n_prev1, n_prev2, hum;
    n_prev1   = '0;
    n_prev2   = '0;
    amp_shift = 4;
    for (k = 0; k < n_items; k++) begin
      if (k % 20 == 0) amp_shift = $urandom_range(0, 15);
      raw_a = SampleW'($urandom);
      raw_b = SampleW'($urandom);
      if ($urandom_range(0, 9) < 7) begin
        n_now = $signed(raw_a) >>> amp_shift;
        hum   = $signed(raw_b) >>> 6;
        d = (3 * int'(n_now) - int'(n_prev2)) / 2 + int'(hum);
        if (d > 32767) d = 32767;
        else if (d < -32768) d = -32768;
        n_prev2 = n_prev1;
        n_prev1 = n_now;
        send_sample(n_now, d[SampleW-1:0]);
      end else begin
        send_sample(raw_a, raw_b);
      end
    end
  endtask

  initial begin
    int               p;
    logic [StepW-1:0] step_v;
    logic             sel_v;
    sb = new();
    calm     = 1'b0;
    hold_req = 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= RegStepSize;
    cfg_wdata_i <= '0;
    in_if.valid            <= 1'b0;
    in_if.reference_sample <= '0;
    in_if.desired_sample   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes at reset settings, error output saturating
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff);
    send_sample(-16'sh0001, 16'sh0001);
    send_sample(16'sh0001, -16'sh0001);
    send_sample(16'sh0000, 16'sh7fff);
    send_sample(16'sh0000, -16'sh8000);
    send_sample(16'sh5555, -16'sh5556);
    drain();

    // largest step drives weights into saturation, desired output selected
    apply_settings(16'hffff, 1'b1);
    for (p = 0; p < 12; p++) begin
      if (p % 2 == 0) send_sample(16'sh7fff, -16'sh8000);
      else send_sample(-16'sh8000, 16'sh7fff);
    end
    drain();

    // saturated weights give a clipped estimate and a 17-bit error
    apply_settings(16'hffff, 1'b0);
    send_sample(16'sh7fff, 16'sh0000);
    send_sample(16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh7fff);
    drain();

    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin step_v = StepReset; sel_v = 1'b0; end
        1: begin step_v = 16'd0;     sel_v = 1'b1; end
        2: begin step_v = 16'd1;     sel_v = 1'b0; end
        3: begin step_v = StepW'($urandom_range(0, 4000));  sel_v = 1'b0; end
        4: begin step_v = 16'hffff;  sel_v = 1'b0; end
        5: begin step_v = StepW'($urandom);  sel_v = 1'b1; end
        6: begin step_v = StepW'($urandom);  sel_v = 1'($urandom_range(0, 1)); end
        default: begin step_v = StepReset; sel_v = 1'b0; end
      endcase
      apply_settings(step_v, sel_v);
      if (p == 1) hold_req = 1'b1;
      if (p == 7) calm = 1'b1;
      run_phase(PHASE_ITEMS);
      drain();
    end

    if (sb.mismatch_count == 0 && sb.pending_out.size() == 0) begin
      $display("[lms_adaptive_noise_canceller] OK");
    end else begin
      $display("[lms_adaptive_noise_canceller] ERROR");
    end
    $finish;
  end

endmodule
